@@ rtl/ssas_pkg.sv @@
package ssas_pkg;

  localparam logic [2:0] KIND_ELEM_LOAD  = 3'd0;
  localparam logic [2:0] KIND_ELEM_STORE = 3'd1;
  localparam logic [2:0] KIND_REPL_LOAD  = 3'd2;
  localparam logic [2:0] KIND_CHUNK_LOAD = 3'd3;
  localparam logic [2:0] KIND_CHUNK_STORE = 3'd4;

  localparam logic [31:0] MULTI_MASK  = 32'hBF20_0000;
  localparam logic [31:0] MULTI_MATCH = 32'h0C00_0000;
  localparam logic [31:0] SINGLE_MASK  = 32'hBF00_0000;
  localparam logic [31:0] SINGLE_MATCH = 32'h0D00_0000;

  localparam logic [3:0] OPC_LD4  = 4'h0;
  localparam logic [3:0] OPC_LD1X4 = 4'h2;
  localparam logic [3:0] OPC_LD3  = 4'h4;
  localparam logic [3:0] OPC_LD1X3 = 4'h6;
  localparam logic [3:0] OPC_LD1X1 = 4'h7;
  localparam logic [3:0] OPC_LD2  = 4'h8;
  localparam logic [3:0] OPC_LD1X2 = 4'hA;

  localparam logic [1:0] SOPC_BYTE = 2'd0;
  localparam logic [1:0] SOPC_HALF = 2'd1;
  localparam logic [1:0] SOPC_WORD = 2'd2;
  localparam logic [1:0] SOPC_REPL = 2'd3;

  typedef enum logic [1:0] {
    MODE_INTER,
    MODE_CHUNK,
    MODE_LANE
  } ssas_mode_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] base_address;
    logic [63:0] offset_register_value;
  } ssas_in_t;

  typedef struct packed {
    logic [2:0]  op_kind;
    logic [4:0]  vector_reg;
    logic [3:0]  lane;
    logic [1:0]  elem_log2;
    logic [63:0] access_address;
    logic        zero_register_first;
    logic        full_width;
    logic        writeback;
    logic [4:0]  writeback_reg;
    logic [63:0] writeback_value;
    logic        undefined;
    logic        last;
  } ssas_out_t;

  typedef struct packed {
    logic       undef;
    ssas_mode_t mode;
    logic [2:0] kind;
    logic [1:0] esz;
    logic [3:0] stride;
    logic [1:0] inner_max;
    logic [3:0] outer_max;
    logic [3:0] lane_idx;
    logic       zero_all;
    logic       zero_first;
    logic       full_width;
    logic       post;
    logic       rm_is_sp;
    logic [4:0] rn;
    logic [4:0] rt;
  } ssas_dec_t;

endpackage

@@ rtl/ssas_decode.sv @@
module ssas_decode import ssas_pkg::*; (
  input  logic [31:0] insn,
  output ssas_dec_t   dec
);

  logic       q, load, s, rgrp;
  logic [1:0] size;
  logic [3:0] opc;
  logic [2:0] sopc;
  logic [4:0] lanes;
  logic [3:0] lanes_m1;
  logic [2:0] regs;
  logic       inter;
  logic       known;

  assign q    = insn[30];
  assign load = insn[22];
  assign s    = insn[12];
  assign rgrp = insn[21];
  assign size = insn[11:10];
  assign opc  = insn[15:12];
  assign sopc = insn[15:13];
  assign lanes    = (q ? 5'd16 : 5'd8) >> size;
  assign lanes_m1 = 4'(lanes - 5'd1);

  always_comb begin
    dec            = '0;
    dec.mode       = MODE_LANE;
    dec.post       = insn[23];
    dec.rm_is_sp   = (insn[20:16] == 5'd31);
    dec.rn         = insn[9:5];
    dec.rt         = insn[4:0];
    dec.full_width = 1'b1;
    regs  = 3'd1;
    inter = 1'b0;
    known = 1'b1;
    if ((insn & MULTI_MASK) == MULTI_MATCH) begin
      unique case (opc)
        OPC_LD4:   begin regs = 3'd4; inter = 1'b1; end
        OPC_LD1X4: begin regs = 3'd4; end
        OPC_LD3:   begin regs = 3'd3; inter = 1'b1; end
        OPC_LD1X3: begin regs = 3'd3; end
        OPC_LD1X1: begin regs = 3'd1; end
        OPC_LD2:   begin regs = 3'd2; inter = 1'b1; end
        OPC_LD1X2: begin regs = 3'd2; end
        default:   known = 1'b0;
      endcase
      if (!known || (size == 2'd3 && !q && regs > 3'd1)) begin
        dec.undef = 1'b1;
      end else if (inter) begin
        dec.mode       = MODE_INTER;
        dec.kind       = load ? KIND_ELEM_LOAD : KIND_ELEM_STORE;
        dec.esz        = size;
        dec.stride     = 4'd1 << size;
        dec.inner_max  = 2'(regs - 3'd1);
        dec.outer_max  = lanes_m1;
        dec.zero_first = load;
      end else begin
        dec.mode       = MODE_CHUNK;
        dec.kind       = load ? KIND_CHUNK_LOAD : KIND_CHUNK_STORE;
        dec.esz        = 2'd3;
        dec.stride     = 4'd8;
        dec.inner_max  = {1'b0, q};
        dec.outer_max  = {2'b00, 2'(regs - 3'd1)};
        dec.zero_first = load;
        dec.full_width = load ? q : 1'b1;
      end
    end else if ((insn & SINGLE_MASK) == SINGLE_MATCH) begin
      dec.inner_max = {sopc[0], rgrp};
      dec.kind      = load ? KIND_ELEM_LOAD : KIND_ELEM_STORE;
      unique case (sopc[2:1])
        SOPC_REPL: begin
          if (!load || s) begin
            dec.undef = 1'b1;
          end else begin
            dec.kind       = KIND_REPL_LOAD;
            dec.esz        = size;
            dec.stride     = 4'd1 << size;
            dec.zero_all   = 1'b1;
            dec.full_width = q;
          end
        end
        SOPC_BYTE: begin
          dec.esz      = 2'd0;
          dec.stride   = 4'd1;
          dec.lane_idx = {q, s, size};
        end
        SOPC_HALF: begin
          if (size[0]) begin
            dec.undef = 1'b1;
          end else begin
            dec.esz      = 2'd1;
            dec.stride   = 4'd2;
            dec.lane_idx = {1'b0, q, s, size[1]};
          end
        end
        SOPC_WORD: begin
          if (size == 2'd0) begin
            dec.esz      = 2'd2;
            dec.stride   = 4'd4;
            dec.lane_idx = {2'b00, q, s};
          end else if (size == 2'd1 && !s) begin
            dec.esz      = 2'd3;
            dec.stride   = 4'd8;
            dec.lane_idx = {3'b000, q};
          end else begin
            dec.undef = 1'b1;
          end
        end
        default: dec.undef = 1'b1;
      endcase
    end else begin
      dec.undef = 1'b1;
    end
    if (dec.undef) begin
      dec.inner_max  = '0;
      dec.outer_max  = '0;
      dec.post       = 1'b0;
      dec.full_width = 1'b0;
    end
  end

endmodule

@@ rtl/ssas_seq.sv @@
module ssas_seq import ssas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  ssas_dec_t   dec,
  input  logic [63:0] base,
  input  logic [63:0] offset,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output ssas_out_t   out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r;
  ssas_dec_t   dec_r;
  logic [63:0] addr_r, base_r, off_r;
  logic [1:0]  inner_r;
  logic [3:0]  outer_r;
  logic        out_valid_r;
  ssas_out_t   out_r;

  logic        step, is_last, use_off, inner_end;
  logic [63:0] add_a, add_b, sum_nxt;
  logic [1:0]  reg_off;
  logic [3:0]  lane;
  ssas_out_t   item_nxt;

  assign step      = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign inner_end = (inner_r == dec_r.inner_max);
  assign is_last   = inner_end && (outer_r == dec_r.outer_max);
  assign use_off   = is_last && dec_r.post && !dec_r.rm_is_sp;

  // single adder: address stride, or base plus Rm on the last item of a post-index by a register other than 31
  assign add_a   = use_off ? base_r : addr_r;
  assign add_b   = use_off ? off_r : {60'd0, dec_r.stride};
  assign sum_nxt = add_a + add_b;

  always_comb begin
    reg_off = inner_r;
    lane    = dec_r.lane_idx;
    case (dec_r.mode)
      MODE_INTER: lane = outer_r;
      MODE_CHUNK: begin
        reg_off = outer_r[1:0];
        lane    = {2'b00, inner_r};
      end
      default: ;
    endcase
    item_nxt = '0;
    item_nxt.last = is_last;
    if (dec_r.undef) begin
      item_nxt.undefined = 1'b1;
    end else begin
      item_nxt.op_kind             = dec_r.kind;
      item_nxt.vector_reg          = dec_r.rt + {3'b000, reg_off};
      item_nxt.lane                = lane;
      item_nxt.elem_log2           = dec_r.esz;
      item_nxt.access_address      = addr_r;
      item_nxt.zero_register_first = dec_r.zero_all | (dec_r.zero_first & (lane == 4'd0));
      item_nxt.full_width          = dec_r.full_width;
      if (is_last && dec_r.post) begin
        item_nxt.writeback       = 1'b1;
        item_nxt.writeback_reg   = dec_r.rn;
        item_nxt.writeback_value = sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
        out_r       <= item_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_RUN;
            dec_r   <= dec;
            addr_r  <= base;
            base_r  <= base;
            off_r   <= offset;
            inner_r <= '0;
            outer_r <= '0;
          end
        end
        ST_RUN: begin
          if (step) begin
            addr_r <= sum_nxt;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else if (inner_end) begin
              inner_r <= '0;
              outer_r <= outer_r + 4'd1;
            end else begin
              inner_r <= inner_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/simd_structure_access_sequencer.sv @@
// The accepted item is registered into the sequencer, then its first micro-op
// into the result register. Throughput: one micro-op per cycle while the result
// side is not stalled; an instruction of n micro-ops (1 to 64) keeps the input
// stalled until its last micro-op is stepped out; the lane/register counters
// step the single 64-bit address adder, and result stalls hold the sequence.
// Reset: synchronous, active low; clears the sequencer state and result valid.
module simd_structure_access_sequencer import ssas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ssas_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ssas_out_t out_data
);

  ssas_dec_t dec;
  logic      busy;
  logic      start;

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  ssas_decode u_decode (
    .insn (in_data.instruction),
    .dec  (dec)
  );

  ssas_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dec       (dec),
    .base      (in_data.base_address),
    .offset    (in_data.offset_register_value),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("sequencer not busy after accepting an item");

  a_undef_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.undefined |-> out_data.last)
    else $error("undefined result is not the last");

  a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.writeback |-> out_data.last)
    else $error("writeback on a non-final micro-op");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last && !busy |=> !out_valid)
    else $error("result after the final micro-op with no new item");

endmodule
